// ----- rtl/core/quadrature_counter_with_rpm_assert.svh -----
// ----------------------------------------------------------------------------
// quadrature counter assertion macros
// shared property forms for the port checker of the quadrature counter
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_COUNTER_WITH_RPM_ASSERT_SVH
`define QUADRATURE_COUNTER_WITH_RPM_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define QCR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qcr check failed: same-cycle rule");

// condition in this cycle implies consequence in the next cycle
`define QCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qcr check failed: next-cycle rule");

// next-cycle rule that also holds through reset
`define QCR_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qcr check failed: reset rule");

`endif

// ----- rtl/core/qcr_pkg.sv -----
// ----------------------------------------------------------------------------
// qcr_pkg
// types and constants of the quadrature counter with speed measurement
// ----------------------------------------------------------------------------
package qcr_pkg;

  localparam int KIND_W     = 2;
  localparam int ELAPSED_W  = 32;
  localparam int POS_W      = 32;
  localparam int RPM_W      = 32;
  localparam int TPR_W      = 16;
  localparam int DEN_W      = ELAPSED_W + TPR_W;
  localparam int SCALE_W    = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 5;

  localparam logic [SCALE_W-1:0] RPM_SCALE = 26'd60000000;
  localparam logic [STEP_W-1:0]  MUL_LAST  = STEP_W'(SCALE_W - 1);
  localparam logic [STEP_W-1:0]  DIV_LAST  = STEP_W'(RPM_W - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE_A = 2'd0,
    KIND_EDGE_B = 2'd1,
    KIND_SPEED  = 2'd2,
    KIND_LOAD   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REVERSED      = 2'd0,
    REG_TICKS_PER_REV = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic mag_load;
    logic mul_step;
    logic chk;
    logic div_step;
    logic finish;
    logic out_load;
  } qcr_cmd_t;

  typedef struct packed {
    logic is_speed;
    logic mul_last;
    logic div_last;
  } qcr_status_t;

endpackage

// ----- rtl/core/qcr_ifs.sv -----
// ----------------------------------------------------------------------------
// qcr interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface qcr_in_if;
  import qcr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic                    level_a;
  logic                    level_b;
  logic [ELAPSED_W-1:0]    elapsed_us;
  logic signed [POS_W-1:0] new_position;

  modport source (output valid, kind, level_a, level_b, elapsed_us, new_position,
                  input ready);
  modport sink (input valid, kind, level_a, level_b, elapsed_us, new_position,
                output ready);
endinterface

interface qcr_out_if;
  import qcr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic                    forward;
  logic [RPM_W-1:0]        rpm;

  modport source (output valid, position, forward, rpm, input ready);
  modport sink (input valid, position, forward, rpm, output ready);
endinterface

interface qcr_cfg_if;
  import qcr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/qcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// qcr_ctrl
// sequencer: item intake, multiply and divide steps, result hand-off
// ----------------------------------------------------------------------------
module qcr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  qcr_pkg::qcr_status_t status,
  output qcr_pkg::qcr_cmd_t    cmd
);
  import qcr_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MAG  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_CHK  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.is_speed ? ST_MAG : ST_DONE;
        end
      end
      ST_MAG: begin
        cmd.mag_load = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/qcr_dp.sv -----
// ----------------------------------------------------------------------------
// qcr_dp
// tick counter, settings, shift-add multiplier, restoring divider, result word
// ----------------------------------------------------------------------------
module qcr_dp #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  qcr_pkg::qcr_cmd_t                      cmd,
  output qcr_pkg::qcr_status_t                   status,
  input  logic                                   cfg_we,
  input  logic [qcr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [qcr_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic [qcr_pkg::KIND_W-1:0]             in_kind,
  input  logic                                   in_level_a,
  input  logic                                   in_level_b,
  input  logic [qcr_pkg::ELAPSED_W-1:0]          in_elapsed_us,
  input  logic signed [qcr_pkg::POS_W-1:0]       in_new_position,
  output logic signed [qcr_pkg::POS_W-1:0]       out_position,
  output logic                                   out_forward,
  output logic [qcr_pkg::RPM_W-1:0]              out_rpm
);
  import qcr_pkg::*;

  localparam int PROD_W = COUNT_WIDTH + SCALE_W;
  localparam int HI_W   = PROD_W - RPM_W;
  localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic                    reversed_r;
  logic [TPR_W-1:0]        tpr_r;
  logic [COUNT_WIDTH-1:0]  count_r;
  logic [COUNT_WIDTH-1:0]  base_r;
  logic                    fwd_r;
  logic [RPM_W-1:0]        speed_r;

  logic [COUNT_WIDTH-1:0]  diff_r;
  logic [DEN_W-1:0]        den_r;
  logic [PROD_W-1:0]       mcand_r;
  logic [PROD_W-1:0]       acc_r;
  logic [DEN_W-1:0]        rem_r;
  logic [RPM_W-1:0]        quo_r;
  logic                    sat_r;
  logic [STEP_W-1:0]       step_r;

  logic signed [POS_W-1:0] pos_r;
  logic                    pos_fwd_r;
  logic [RPM_W-1:0]        rpm_r;

  logic                    up;
  logic [COUNT_WIDTH-1:0]  mag;
  logic [CMP_W-1:0]        hi_ext;
  logic [CMP_W-1:0]        den_ext;
  logic [DEN_W:0]          trial;
  logic [DEN_W:0]          trial_diff;
  logic                    trial_ge;

  assign up = in_level_a ^ in_level_b ^ reversed_r ^ (in_kind == KIND_EDGE_B);
  assign mag = diff_r[COUNT_WIDTH-1] ? COUNT_WIDTH'(-diff_r) : diff_r;

  assign hi_ext  = CMP_W'(acc_r >> RPM_W);
  assign den_ext = CMP_W'(den_r);

  assign trial      = {rem_r, quo_r[RPM_W-1]};
  assign trial_diff = trial - {1'b0, den_r};
  assign trial_ge   = (trial >= {1'b0, den_r});

  assign status.is_speed = (in_kind == KIND_SPEED);
  assign status.mul_last = (step_r == MUL_LAST);
  assign status.div_last = (step_r == DIV_LAST);

  assign out_position = pos_r;
  assign out_forward  = pos_fwd_r;
  assign out_rpm      = rpm_r;

  // settings and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reversed_r <= 1'b0;
      tpr_r      <= TPR_W'(1);
      count_r    <= '0;
      base_r     <= '0;
      fwd_r      <= 1'b1;
      speed_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REVERSED:      reversed_r <= cfg_data[0];
          REG_TICKS_PER_REV: tpr_r      <= cfg_data[TPR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (in_kind)
          KIND_EDGE_A, KIND_EDGE_B: begin
            count_r <= up ? count_r + COUNT_WIDTH'(1) : count_r - COUNT_WIDTH'(1);
            fwd_r   <= up;
          end
          KIND_SPEED: begin
            base_r <= count_r;
          end
          KIND_LOAD: begin
            count_r <= COUNT_WIDTH'(in_new_position);
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        speed_r <= sat_r ? '1 : quo_r;
      end
    end
  end

  // speed arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      diff_r <= count_r - base_r;
      den_r  <= DEN_W'(in_elapsed_us) * DEN_W'(tpr_r);
    end
    if (cmd.mag_load) begin
      mcand_r <= PROD_W'(mag);
      acc_r   <= '0;
      step_r  <= '0;
    end
    if (cmd.mul_step) begin
      if (RPM_SCALE[step_r]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r <= mcand_r << 1;
      step_r  <= step_r + STEP_W'(1);
    end
    if (cmd.chk) begin
      sat_r  <= (hi_ext >= den_ext);
      rem_r  <= hi_ext[DEN_W-1:0];
      quo_r  <= acc_r[RPM_W-1:0];
      step_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r  <= {quo_r[RPM_W-2:0], trial_ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_r     <= POS_W'(signed'(count_r));
      pos_fwd_r <= fwd_r;
      rpm_r     <= speed_r;
    end
  end

endmodule

// ----- rtl/core/quadrature_counter_with_rpm.sv -----
// ----------------------------------------------------------------------------
// quadrature_counter_with_rpm
// x4 quadrature decoder with position load and rpm measurement
// ----------------------------------------------------------------------------
// Each input word is an edge on channel A or B, a speed sample or a position
// load, and each one returns one result word with position, direction and the
// last rpm figure. Edge and load words go from acceptance through the done
// state to the result register, which they enter once it is free. A speed
// sample runs in steps: the position difference and the 32x16 divisor product,
// the magnitude, shift-add multiplication by 60000000, an overflow check and
// a restoring divider, one bit per cycle, then storing the speed and loading
// the result. One word is in flight at a time; the next word is taken while
// a finished result still waits in the output register.
// A zero divisor or a quotient above 32 bits gives rpm of all ones.
module quadrature_counter_with_rpm #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  qcr_in_if.sink    in_ch,
  qcr_out_if.source out_ch,
  qcr_cfg_if.sink   cfg_ch
);
  import qcr_pkg::*;

  qcr_cmd_t    cmd;
  qcr_status_t status;
  logic        cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid & cfg_ch.ready;

  qcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  qcr_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .in_kind         (in_ch.kind),
    .in_level_a      (in_ch.level_a),
    .in_level_b      (in_ch.level_b),
    .in_elapsed_us   (in_ch.elapsed_us),
    .in_new_position (in_ch.new_position),
    .out_position    (out_ch.position),
    .out_forward     (out_ch.forward),
    .out_rpm         (out_ch.rpm)
  );

endmodule

// ----- rtl/core/qcr_checker.sv -----
// ----------------------------------------------------------------------------
// qcr_checker
// port-level checks of the quadrature counter, bound to the top level
// ----------------------------------------------------------------------------
`include "quadrature_counter_with_rpm_assert.svh"

module qcr_checker (
  input logic       clk,
  input logic       rst_n,
  qcr_in_if.sink    in_ch,
  qcr_out_if.source out_ch
);

  // a stalled result word holds
  `QCR_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.position) && $stable(out_ch.forward) && $stable(out_ch.rpm))

  // one word in flight: intake closes right after acceptance
  `QCR_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready)

  // with nothing in flight a taken result leaves the output empty
  `QCR_ASSERT_NEXT(a_no_phantom, out_ch.valid && out_ch.ready && in_ch.ready, !out_ch.valid)

  // reset empties the output
  `QCR_ASSERT_RESET(a_reset_out, !rst_n, !out_ch.valid)

endmodule

bind quadrature_counter_with_rpm qcr_checker u_qcr_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
